// ===== src/hsu_pkg.sv =====
// Package for the detector hit stream unpacker.
// Holds the channel payload types, the queued message record and shared constants.
// No dependencies.
package hsu_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;

  localparam int HC_W  = 5;
  localparam int AC_W  = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int POS_W = 10;

  localparam int PKT_HDR_BYTES = 4;
  localparam int MSG_LAST      = 5;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [3:0] TYPE_HIT   = 4'd1;
  localparam logic [3:0] TYPE_EPOCH = 4'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PACKET = 2'd1,
    PH_PAD    = 2'd2
  } hsu_phase_t;

  typedef enum logic {
    MSG_HIT   = 1'b0,
    MSG_EPOCH = 1'b1
  } hsu_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        slice_first;
    logic [15:0] equipment_id;
  } hsu_in_t;

  typedef struct packed {
    logic [15:0] hit_equipment;
    logic [17:0] front_end_id;
    logic [6:0]  channel;
    logic [31:0] hit_epoch;
    logic [13:0] timestamp;
    logic [11:0] adc_value;
    logic        pile_up;
    logic        overflow;
  } hsu_out_t;

  typedef struct packed {
    hsu_kind_t   kind;
    logic [15:0] equipment_id;
    logic [15:0] readout_id;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    logic [7:0]  b5;
  } hsu_msg_t;

endpackage

// ===== src/hsu_parser.sv =====
// Front end: byte-level parser of microslices, packets and padding.
// Gathers 6-byte messages and forwards hit and epoch messages. Uses hsu_pkg.
module hsu_parser import hsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  hsu_in_t  in_data,
  output logic     push,
  output hsu_msg_t push_msg
);

  hsu_phase_t       phase_r, phase_nxt, ph_eff;
  logic [HC_W-1:0]  hc_r, hc_nxt, hc_eff;
  logic [AC_W-1:0]  ac_r, ac_nxt, ac_eff;
  logic [7:0]       len_r, len_nxt, len_eff;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff, pos_inc, pkt_total;
  logic [15:0]      rid_r, rid_nxt;
  logic [2:0]       midx_r, midx_nxt;
  logic [7:0]       mbytes_r [0:4];
  logic [3:0]       msg_type;

  // phase after slice restart and phase change at the start of this byte
  always_comb begin
    ph_eff  = in_data.slice_first ? PH_HEADER : phase_r;
    hc_eff  = in_data.slice_first ? '0 : hc_r;
    ac_eff  = in_data.slice_first ? '0 : ac_r;
    pos_eff = pos_r;
    if (ph_eff == PH_HEADER && hc_eff >= HC_W'(HEADER_BYTES)) begin
      ph_eff  = PH_PACKET;
      pos_eff = '0;
    end else if (ph_eff == PH_PAD && ac_eff == '0) begin
      ph_eff  = PH_PACKET;
      pos_eff = '0;
    end
    len_eff   = (pos_eff == '0) ? in_data.data_byte : len_r;
    pos_inc   = pos_eff + POS_W'(1);
    pkt_total = {1'b0, len_eff, 1'b0} + POS_W'(PKT_HDR_BYTES);
  end

  // next state
  always_comb begin
    phase_nxt = ph_eff;
    hc_nxt    = hc_eff;
    ac_nxt    = (ac_eff == AC_W'(ALIGN_BYTES - 1)) ? '0 : ac_eff + AC_W'(1);
    len_nxt   = len_r;
    pos_nxt   = pos_eff;
    rid_nxt   = rid_r;
    midx_nxt  = midx_r;
    unique case (ph_eff)
      PH_HEADER: begin
        hc_nxt = hc_eff + HC_W'(1);
      end
      PH_PACKET: begin
        if (pos_eff == POS_W'(0)) begin
          len_nxt = in_data.data_byte;
        end else if (pos_eff == POS_W'(2)) begin
          rid_nxt = {rid_r[15:8], in_data.data_byte};
        end else if (pos_eff == POS_W'(3)) begin
          rid_nxt = {in_data.data_byte, rid_r[7:0]};
        end
        if (pos_eff >= POS_W'(PKT_HDR_BYTES)) begin
          midx_nxt = (midx_r == 3'(MSG_LAST)) ? 3'd0 : midx_r + 3'd1;
        end else begin
          midx_nxt = 3'd0;
        end
        if (pos_inc >= POS_W'(PKT_HDR_BYTES) && pos_inc >= pkt_total) begin
          phase_nxt = PH_PAD;
          pos_nxt   = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      PH_PAD: begin
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // outputs
  always_comb begin
    msg_type              = in_data.data_byte[3:0];
    push_msg.kind         = (msg_type == TYPE_EPOCH) ? MSG_EPOCH : MSG_HIT;
    push_msg.equipment_id = in_data.equipment_id;
    push_msg.readout_id   = rid_r;
    push_msg.b0           = mbytes_r[0];
    push_msg.b1           = mbytes_r[1];
    push_msg.b2           = mbytes_r[2];
    push_msg.b3           = mbytes_r[3];
    push_msg.b4           = mbytes_r[4];
    push_msg.b5           = in_data.data_byte;
    push = accept && ph_eff == PH_PACKET && pos_eff >= POS_W'(PKT_HDR_BYTES)
           && midx_r == 3'(MSG_LAST)
           && (msg_type == TYPE_HIT || msg_type == TYPE_EPOCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hc_r    <= '0;
      ac_r    <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      rid_r   <= '0;
      midx_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      ac_r    <= ac_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      rid_r   <= rid_nxt;
      midx_r  <= midx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ph_eff == PH_PACKET && pos_eff >= POS_W'(PKT_HDR_BYTES)
        && midx_r < 3'(MSG_LAST)) begin
      mbytes_r[midx_r] <= in_data.data_byte;
    end
  end

`ifndef SYNTHESIS
  a_midx_range: assert property (@(posedge clk) disable iff (!rst_n)
    midx_r <= 3'(MSG_LAST))
    else $error("message byte index out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(2 * 255 + PKT_HDR_BYTES))
    else $error("packet position beyond longest packet");
`endif

endmodule

// ===== src/hsu_queue.sv =====
// Short message queue between parser and decoder.
// Register-based FIFO of hsu_msg_t records. Uses hsu_pkg.
module hsu_queue import hsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hsu_msg_t push_msg,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output hsu_msg_t head_msg
);

  hsu_msg_t        entry_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_msg  = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_msg;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== src/hsu_decoder.sv =====
// Back end: epoch tracking and hit field decode into the output register.
// Consumes queued messages in order. Uses hsu_pkg.
module hsu_decoder import hsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     not_empty,
  input  hsu_msg_t head_msg,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output hsu_out_t out_data
);

  logic [31:0] epoch_r;
  logic        out_valid_r;
  hsu_out_t    out_r, out_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = not_empty && (head_msg.kind == MSG_EPOCH || slot_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    out_nxt.hit_equipment = head_msg.equipment_id;
    out_nxt.front_end_id  = {head_msg.readout_id, head_msg.b5[7:6]};
    out_nxt.channel       = head_msg.b2[7:1];
    out_nxt.hit_epoch     = epoch_r - {31'd0, head_msg.b0[7]};
    out_nxt.timestamp     = {head_msg.b2[0], head_msg.b3, head_msg.b4[7:3]};
    out_nxt.adc_value     = {head_msg.b0[4:0], head_msg.b1[7:1]};
    out_nxt.pile_up       = head_msg.b0[5];
    out_nxt.overflow      = head_msg.b0[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && head_msg.kind == MSG_EPOCH) begin
        epoch_r <= {head_msg.b1, head_msg.b2, head_msg.b3, head_msg.b4};
      end
      if (pop && head_msg.kind == MSG_HIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_msg.kind == MSG_HIT) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && not_empty && head_msg.kind == MSG_HIT) |-> !pop)
    else $error("hit popped while result register is held");
`endif

endmodule

// ===== src/detector_hit_stream_unpacker.sv =====
// Top level of the detector hit stream unpacker: parser, message queue, decoder.
// Depends on hsu_pkg, hsu_parser, hsu_queue and hsu_decoder.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_stall   | hsu_in_t  (one byte of a microslice)
//   out_    | out | out_valid / out_stall | hsu_out_t (one decoded hit)
//
// A byte is taken each cycle unless in_stall; a hit reaches out_ via queue and out_r.
// Rate is set by the byte parser: one byte per cycle unless stalled, no iteration.
// in_stall rises only while the four-entry message queue is full.
// out_stall holds the result register; epoch messages still drain behind it.
// Reset is synchronous; there is no clearing pass.
module detector_hit_stream_unpacker import hsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hsu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hsu_out_t out_data
);

  logic     accept;
  logic     push, pop, full, not_empty;
  hsu_msg_t push_msg, head_msg;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  hsu_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .push     (push),
    .push_msg (push_msg)
  );

  hsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_msg  (push_msg),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_msg  (head_msg)
  );

  hsu_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head_msg  (head_msg),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
